// ===== sv/cvgf_pkg.sv =====
// ----------------------------------------------------------------------------
// cvgf_pkg
// Shared widths, types and codes for the cell voltage glitch filter.
// ----------------------------------------------------------------------------
package cvgf_pkg;

    localparam int CHIPS          = 8;
    localparam int CELLS_PER_CHIP = 12;
    localparam int CELL_TOTAL     = CHIPS * CELLS_PER_CHIP;
    localparam int SLOT_W         = $clog2(CELL_TOTAL);

    localparam int CHIP_W   = 3;
    localparam int CELL_W   = 4;
    localparam int VOLT_W   = 16;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [VOLT_W-1:0]  MAX_DELTA_RST        = 16'd1000;
    localparam logic [COUNT_W-1:0] MAX_REJECT_COUNT_RST = 8'd10;

    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [VOLT_W-1:0]  t_volt;
    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT    = 2'd0,
        ST_HELD_JUMP = 2'd1,
        ST_FORCED    = 2'd2,
        ST_HELD_BAD  = 2'd3
    } t_status;

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_MAX_DELTA        = 1'b0,
        REG_MAX_REJECT_COUNT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_volt  voltage;
        t_count count;
    } t_entry;

    typedef struct packed {
        t_volt  max_delta;
        t_count max_reject_count;
    } t_cfg;

    typedef struct packed {
        logic   en;
        t_slot  slot;
        t_entry data;
    } t_wr_req;

endpackage

// ===== sv/cvgf_if.sv =====
// ----------------------------------------------------------------------------
// cvgf_if
// Sample and result channels of the cell voltage glitch filter.
// ----------------------------------------------------------------------------
interface cvgf_sample_if;
    logic                        valid;
    logic                        ready;
    logic [cvgf_pkg::CHIP_W-1:0] chip_index;
    logic [cvgf_pkg::CELL_W-1:0] cell_index;
    logic [cvgf_pkg::VOLT_W-1:0] raw_voltage;
    logic                        read_ok;

    modport source (output valid, chip_index, cell_index, raw_voltage, read_ok,
                    input ready);
    modport sink   (input valid, chip_index, cell_index, raw_voltage, read_ok,
                    output ready);
endinterface

interface cvgf_result_if;
    logic                          valid;
    logic                          ready;
    logic [cvgf_pkg::VOLT_W-1:0]   filtered_voltage;
    logic [cvgf_pkg::STATUS_W-1:0] status;

    modport source (output valid, filtered_voltage, status, input ready);
    modport sink   (input valid, filtered_voltage, status, output ready);
endinterface

// ===== sv/cvgf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cvgf_cfg_regs
// APB register file holding the jump threshold and the rejection limit.
// ----------------------------------------------------------------------------
module cvgf_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cvgf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cvgf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cvgf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output cvgf_pkg::t_cfg                  o_cfg
);

    cvgf_pkg::t_cfg     r_cfg;
    cvgf_pkg::t_reg_idx reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = cvgf_pkg::t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_delta        <= cvgf_pkg::MAX_DELTA_RST;
            r_cfg.max_reject_count <= cvgf_pkg::MAX_REJECT_COUNT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                cvgf_pkg::REG_MAX_DELTA: begin
                    r_cfg.max_delta <= pwdata[cvgf_pkg::VOLT_W-1:0];
                end
                cvgf_pkg::REG_MAX_REJECT_COUNT: begin
                    r_cfg.max_reject_count <= pwdata[cvgf_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cvgf_pkg::REG_MAX_DELTA: begin
                prdata = cvgf_pkg::APB_DATA_W'(r_cfg.max_delta);
            end
            cvgf_pkg::REG_MAX_REJECT_COUNT: begin
                prdata = cvgf_pkg::APB_DATA_W'(r_cfg.max_reject_count);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/cvgf_cell_store.sv =====
// ----------------------------------------------------------------------------
// cvgf_cell_store
// Per-cell memory of last voltage and rejection count, one read and one
// write port, registered read. Written flags make unwritten entries read 0.
// ----------------------------------------------------------------------------
module cvgf_cell_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  cvgf_pkg::t_slot  i_rd_slot,
    output cvgf_pkg::t_entry o_rd_data,
    input  cvgf_pkg::t_wr_req i_wr
);

    cvgf_pkg::t_entry                  r_mem [cvgf_pkg::CELL_TOTAL];
    cvgf_pkg::t_entry                  r_rd_data;
    logic [cvgf_pkg::CELL_TOTAL-1:0]   r_written;
    logic                              r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.slot] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_written[i_wr.slot] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_written <= r_written[i_rd_slot];
            end
        end
    end

    assign o_rd_data = r_rd_written ? r_rd_data : '0;

endmodule

// ===== sv/cvgf_update.sv =====
// ----------------------------------------------------------------------------
// cvgf_update
// Filter decision for one sample: compare against the stored voltage,
// update the rejection count, pick the reported voltage and status.
// ----------------------------------------------------------------------------
module cvgf_update (
    input  cvgf_pkg::t_cfg    i_cfg,
    input  cvgf_pkg::t_entry  i_prev,
    input  cvgf_pkg::t_volt   i_raw,
    input  logic              i_read_ok,
    input  logic              i_in_range,
    output cvgf_pkg::t_entry  o_next,
    output logic              o_write,
    output cvgf_pkg::t_volt   o_report,
    output cvgf_pkg::t_status o_status
);

    cvgf_pkg::t_volt              delta_abs;
    logic [cvgf_pkg::COUNT_W:0]   cnt_inc;
    logic                         jump;
    logic                         force_through;

    assign delta_abs = (i_raw >= i_prev.voltage) ? (i_raw - i_prev.voltage)
                                                 : (i_prev.voltage - i_raw);
    assign jump    = delta_abs > i_cfg.max_delta;
    // one bit wider so a full count still exceeds the top limit
    assign cnt_inc = {1'b0, i_prev.count} + {{cvgf_pkg::COUNT_W{1'b0}}, 1'b1};
    assign force_through = cnt_inc > {1'b0, i_cfg.max_reject_count};

    always_comb begin
        o_next   = i_prev;
        o_write  = 1'b0;
        o_report = i_prev.voltage;
        o_status = cvgf_pkg::ST_HELD_BAD;
        priority if (!i_in_range) begin
            o_report = '0;
        end else if (!i_read_ok) begin
            o_report = i_prev.voltage;
        end else if (!jump) begin
            o_write        = 1'b1;
            o_next.voltage = i_raw;
            o_next.count   = '0;
            o_report       = i_raw;
            o_status       = cvgf_pkg::ST_ACCEPT;
        end else if (force_through) begin
            o_write        = 1'b1;
            o_next.voltage = i_raw;
            o_next.count   = '0;
            o_report       = i_raw;
            o_status       = cvgf_pkg::ST_FORCED;
        end else begin
            o_write      = 1'b1;
            o_next.count = cnt_inc[cvgf_pkg::COUNT_W-1:0];
            o_status     = cvgf_pkg::ST_HELD_JUMP;
        end
    end

endmodule

// ===== sv/cell_voltage_glitch_filter.sv =====
// ----------------------------------------------------------------------------
// cell_voltage_glitch_filter
// Per-cell spike rejection with a persistence count over a sample stream.
// ----------------------------------------------------------------------------
// Pipeline: an accepted sample is registered in stage 1 while its cell entry is read,
//   then its result is registered in the output register that drives o_result.
// Throughput: one sample per cycle while o_result is not stalled; the cell store
//   read-modify-write (registered read, write-back as stage 1 advances, bypass on
//   same-cell hits) sustains this rate. Reset: clears the per-entry written flags,
//   so all cells read zero voltage and count; registers return to 1000 and 10.
module cell_voltage_glitch_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cvgf_sample_if.sink                     i_sample,
    cvgf_result_if.source                   o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cvgf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cvgf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cvgf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    cvgf_pkg::t_cfg    cfg;
    cvgf_pkg::t_slot   in_slot;
    logic              in_range;
    logic              in_acc;
    logic              out_free;
    logic              s1_adv;
    cvgf_pkg::t_entry  rd_entry;
    cvgf_pkg::t_entry  prev_entry;
    cvgf_pkg::t_entry  next_entry;
    logic              upd_write;
    cvgf_pkg::t_volt   report;
    cvgf_pkg::t_status status;
    cvgf_pkg::t_wr_req wr_req;

    // stage 1: sample waiting on its memory read
    logic              r_s1_vld;
    cvgf_pkg::t_slot   r_s1_slot;
    cvgf_pkg::t_volt   r_s1_raw;
    logic              r_s1_ok;
    logic              r_s1_in_range;

    // last write, to bypass a read that raced it
    logic              r_fw_vld;
    cvgf_pkg::t_slot   r_fw_slot;
    cvgf_pkg::t_entry  r_fw_data;

    // output register
    logic              r_out_vld;
    cvgf_pkg::t_volt   r_out_voltage;
    cvgf_pkg::t_status r_out_status;

    cvgf_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign in_range = (int'(i_sample.chip_index) < cvgf_pkg::CHIPS) &&
                      (int'(i_sample.cell_index) < cvgf_pkg::CELLS_PER_CHIP);
    assign in_slot  = cvgf_pkg::t_slot'(i_sample.chip_index) *
                      cvgf_pkg::t_slot'(cvgf_pkg::CELLS_PER_CHIP) +
                      cvgf_pkg::t_slot'(i_sample.cell_index);

    assign out_free       = !r_out_vld || o_result.ready;
    assign s1_adv         = r_s1_vld && out_free;
    assign i_sample.ready = !r_s1_vld || out_free;
    assign in_acc         = i_sample.valid && i_sample.ready;

    cvgf_cell_store u_cell_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc && in_range),
        .i_rd_slot (in_slot),
        .o_rd_data (rd_entry),
        .i_wr      (wr_req)
    );

    assign prev_entry = (r_fw_vld && (r_fw_slot == r_s1_slot)) ? r_fw_data : rd_entry;

    cvgf_update u_update (
        .i_cfg      (cfg),
        .i_prev     (prev_entry),
        .i_raw      (r_s1_raw),
        .i_read_ok  (r_s1_ok),
        .i_in_range (r_s1_in_range),
        .o_next     (next_entry),
        .o_write    (upd_write),
        .o_report   (report),
        .o_status   (status)
    );

    assign wr_req.en   = s1_adv && upd_write;
    assign wr_req.slot = r_s1_slot;
    assign wr_req.data = next_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fw_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_sample.ready) begin
                r_s1_vld <= i_sample.valid;
            end
            if (wr_req.en) begin
                r_fw_vld <= 1'b1;
            end
            if (out_free) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_slot     <= in_range ? in_slot : '0;
            r_s1_raw      <= i_sample.raw_voltage;
            r_s1_ok       <= i_sample.read_ok;
            r_s1_in_range <= in_range;
        end
        if (wr_req.en) begin
            r_fw_slot <= wr_req.slot;
            r_fw_data <= wr_req.data;
        end
        if (s1_adv) begin
            r_out_voltage <= report;
            r_out_status  <= status;
        end
    end

    assign o_result.valid            = r_out_vld;
    assign o_result.filtered_voltage = r_out_voltage;
    assign o_result.status           = r_out_status;

endmodule

// ===== sv/cvgf_checker.sv =====
// ----------------------------------------------------------------------------
// cvgf_checker
// Port-level checks on the glitch filter, bound to the top level.
// ----------------------------------------------------------------------------
module cvgf_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [cvgf_pkg::CHIP_W-1:0]     i_in_chip,
    input  logic [cvgf_pkg::CELL_W-1:0]     i_in_cell,
    input  logic                            i_in_ok,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [cvgf_pkg::VOLT_W-1:0]     i_out_voltage,
    input  logic [cvgf_pkg::STATUS_W-1:0]   i_out_status
);

    logic in_acc;
    logic in_oor;

    assign in_acc = i_in_valid && i_in_ready;
    assign in_oor = (int'(i_in_chip) >= cvgf_pkg::CHIPS) ||
                    (int'(i_in_cell) >= cvgf_pkg::CELLS_PER_CHIP);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_bad_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_in_ok ##1 i_out_ready |=>
            i_out_valid && (i_out_status == cvgf_pkg::ST_HELD_BAD))
        else $error("bad read not reported as held");

    a_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && in_oor ##1 i_out_ready |=>
            i_out_valid && (i_out_voltage == '0) &&
            (i_out_status == cvgf_pkg::ST_HELD_BAD))
        else $error("out-of-range sample not reported as zero and held");

endmodule

bind cell_voltage_glitch_filter cvgf_checker u_cvgf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_sample.valid),
    .i_in_ready    (i_sample.ready),
    .i_in_chip     (i_sample.chip_index),
    .i_in_cell     (i_sample.cell_index),
    .i_in_ok       (i_sample.read_ok),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_voltage (o_result.filtered_voltage),
    .i_out_status  (o_result.status)
);
